[hdl/sps_pkg.sv]
`default_nettype none

package sps_pkg;

  localparam int unsigned CoilCount = 4;
  localparam int unsigned UnitsW    = 3;
  localparam int unsigned HoldUsW   = 19;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned CfgAddrW  = 2;

  // register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] CfgHalfStep     = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgCoilReversed = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgStepPeriod   = 2'd2;

  localparam logic [PeriodW-1:0] PeriodReset = 16'd2441;

  // hold in base periods
  localparam logic [UnitsW-1:0] HoldSlow = 3'd5;
  localparam logic [UnitsW-1:0] HoldFast = 3'd1;

  // ramp zones for auto speed
  localparam int unsigned RampZone0 = 20;
  localparam int unsigned RampZone1 = 10;
  localparam int unsigned RampZone2 = 5;

  typedef enum logic {
    KindStart   = 1'b0,
    KindAdvance = 1'b1
  } sps_kind_e;

  typedef enum logic [1:0] {
    SpeedSlow = 2'd0,
    SpeedAuto = 2'd1,
    SpeedFast = 2'd2
  } sps_speed_e;

  typedef struct packed {
    logic half_step;
    logic coil_order_reversed;
  } sps_cfg_t;

  typedef struct packed {
    logic [CoilCount-1:0] coils;
    logic [UnitsW-1:0]    hold_units;
    logic                 last_step;
    logic                 idle;
  } sps_step_t;

endpackage

`default_nettype wire

[hdl/sps_core.sv]
`default_nettype none

module sps_core #(
  parameter int unsigned STEP_BITS = 20
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic                        kind_i,
  input  wire logic signed [STEP_BITS-1:0] step_count_i,
  input  wire logic [1:0]                  speed_mode_i,
  input  wire sps_pkg::sps_cfg_t           cfg_i,
  output logic                             emit_o,
  output sps_pkg::sps_step_t               step_o
);
  import sps_pkg::*;

  localparam int unsigned CntW = STEP_BITS - 1;

  logic [2:0]      phase_q, phase_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] index_q, index_d;
  logic            backward_q, backward_d;
  logic [1:0]      speed_q, speed_d;

  logic                 neg;
  logic [STEP_BITS-1:0] mag_full;
  logic [CntW-1:0]      mag;
  logic                 active;
  logic [CntW-1:0]      left;
  logic [2:0]           delta;
  logic [2:0]           phase_sum;
  logic [2:0]           phase_nxt;
  logic [UnitsW-1:0]    units;
  logic [CoilCount-1:0] pattern;
  logic [CoilCount-1:0] pattern_out;

  // start item: magnitude, with the most negative count saturated
  assign neg      = step_count_i[STEP_BITS-1];
  assign mag_full = neg ? (~step_count_i + STEP_BITS'(1)) : step_count_i;
  assign mag      = mag_full[STEP_BITS-1] ? '1 : mag_full[CntW-1:0];

  assign active = index_q < total_q;
  assign left   = total_q - index_q;

  // backward is +(n-1) mod n; an out-of-range phase folds in the same add
  assign delta     = backward_q ? (cfg_i.half_step ? 3'd7 : 3'd3) : 3'd1;
  assign phase_sum = phase_q + delta;
  assign phase_nxt = cfg_i.half_step ? phase_sum : {1'b0, phase_sum[1:0]};

  always_comb begin
    units = HoldFast;
    case (speed_q)
      SpeedSlow: begin
        units = HoldSlow;
      end
      SpeedAuto: begin
        units = 3'd1
              + UnitsW'(index_q < CntW'(RampZone0))
              + UnitsW'(index_q < CntW'(RampZone1))
              + UnitsW'(index_q < CntW'(RampZone2))
              + UnitsW'(left < CntW'(RampZone0))
              + UnitsW'(left < CntW'(RampZone1))
              + UnitsW'(left < CntW'(RampZone2));
      end
      default: begin
        units = HoldFast;
      end
    endcase
  end

  always_comb begin
    pattern = '0;
    if (cfg_i.half_step) begin
      pattern[phase_nxt[2:1]] = 1'b1;
      if (phase_nxt[0]) begin
        pattern[phase_nxt[2:1] + 2'd1] = 1'b1;
      end
    end else begin
      pattern[phase_nxt[1:0]] = 1'b1;
    end
    for (int i = 0; i < CoilCount; i++) begin
      pattern_out[i] = cfg_i.coil_order_reversed ? pattern[CoilCount-1-i] : pattern[i];
    end
  end

  always_comb begin
    phase_d    = phase_q;
    total_d    = total_q;
    index_d    = index_q;
    backward_d = backward_q;
    speed_d    = speed_q;
    emit_o     = 1'b1;
    step_o     = '{coils: '0, hold_units: '0, last_step: 1'b0, idle: 1'b1};
    if (kind_i == KindStart) begin
      speed_d    = speed_mode_i;
      backward_d = neg;
      index_d    = '0;
      total_d    = mag;
      emit_o     = (mag == '0);
    end else if (active) begin
      phase_d = phase_nxt;
      index_d = index_q + CntW'(1);
      step_o  = '{coils: pattern_out, hold_units: units,
                  last_step: (left == CntW'(1)), idle: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      total_q    <= '0;
      index_q    <= '0;
      backward_q <= 1'b0;
      speed_q    <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      total_q    <= total_d;
      index_q    <= index_d;
      backward_q <= backward_d;
      speed_q    <= speed_d;
    end
  end

endmodule

`default_nettype wire

[hdl/stepper_phase_sequencer_top.sv]
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------------------------
// cfg       | in        | cfg_we_i                   | cfg_addr_i, cfg_wdata_i
// in        | in        | in_valid_i / in_ready_o    | kind_i, step_count_i, speed_mode_i
// out       | out       | out_valid_o / out_ready_i  | coils_o, hold_us_o, hold_units_o,
//           |           |                            | last_step_o, idle_o
//
// One item per cycle while the output does not stall. After its item is accepted,
// the step decision is registered, then the period multiply is registered.
// A start item with a nonzero count updates the move and gives no result.
// The two result registers let in_ready_o stay high while one result waits.
// Reset clears the move state and restores the register defaults.
`default_nettype none

module stepper_phase_sequencer_top #(
  parameter int unsigned STEP_BITS = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sps_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [sps_pkg::PeriodW-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic signed [STEP_BITS-1:0]   step_count_i,
  input  wire logic [1:0]                    speed_mode_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sps_pkg::CoilCount-1:0]      coils_o,
  output logic [sps_pkg::HoldUsW-1:0]        hold_us_o,
  output logic [sps_pkg::UnitsW-1:0]         hold_units_o,
  output logic                               last_step_o,
  output logic                               idle_o
);
  import sps_pkg::*;

  logic               half_q, rev_q;
  logic [PeriodW-1:0] period_q;
  sps_cfg_t           cfg;

  logic      fire;
  logic      emit;
  sps_step_t step;

  logic      s1_valid_q;
  sps_step_t s1_q;
  logic      s1_adv;
  logic      out_free;

  logic                 out_valid_q;
  logic [CoilCount-1:0] coils_q;
  logic [HoldUsW-1:0]   hold_us_q, hold_us_d;
  logic [UnitsW-1:0]    units_q;
  logic                 last_q, idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= 1'b1;
      rev_q    <= 1'b0;
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgHalfStep:     half_q   <= cfg_wdata_i[0];
        CfgCoilReversed: rev_q    <= cfg_wdata_i[0];
        CfgStepPeriod:   period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg = '{half_step: half_q, coil_order_reversed: rev_q};

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign fire       = in_valid_i && in_ready_o;

  sps_core #(
    .STEP_BITS(STEP_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .kind_i       (kind_i),
    .step_count_i (step_count_i),
    .speed_mode_i (speed_mode_i),
    .cfg_i        (cfg),
    .emit_o       (emit),
    .step_o       (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (fire && emit) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      s1_q <= step;
    end
  end

  assign hold_us_d = HoldUsW'({{PeriodW{1'b0}}, s1_q.hold_units}
                            * {{UnitsW{1'b0}}, period_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      coils_q   <= s1_q.coils;
      hold_us_q <= hold_us_d;
      units_q   <= s1_q.hold_units;
      last_q    <= s1_q.last_step;
      idle_q    <= s1_q.idle;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign coils_o      = coils_q;
  assign hold_us_o    = hold_us_q;
  assign hold_units_o = units_q;
  assign last_step_o  = last_q;
  assign idle_o       = idle_q;

`ifndef SYNTHESIS
  a_idle_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> coils_o == '0 && hold_us_o == '0 && !last_step_o)
    else $error("idle result drives coils or hold");

  a_step_has_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !idle_o |-> hold_units_o != '0 && coils_o != '0)
    else $error("step result without hold or coils");

  a_hold_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hold_us_o == HoldUsW'({{PeriodW{1'b0}}, hold_units_o}
                                         * {{UnitsW{1'b0}}, period_q}))
    else $error("hold_us does not match hold units times period");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty decision stage");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("waiting item dropped or changed");
`endif

endmodule

`default_nettype wire
